/* rtl/btt_pkg.sv */
`default_nettype none

package btt_pkg;

    localparam int ID_W       = 16;
    localparam int LIMIT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int RESULT_CAP = 16;

    // Request codes as they arrive on the request channel.
    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TOGGLE = 3'd2,
        OP_SET_EN = 3'd3,
        OP_LIST   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // A classified request as it waits in the command queue.
    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    id;
        logic               en;
        logic [LIMIT_W-1:0] limit;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              active_now;
        logic [ID_W-1:0]   listed_id;
        logic              last;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/btt_if.sv */
`default_nettype none

// Request channel.
interface btt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] member_id;
    logic        enable_value;
    logic [4:0]  list_limit;

    modport source (output valid, output req_type, output member_id,
                    output enable_value, output list_limit, input ready);
    modport sink   (input valid, input req_type, input member_id,
                    input enable_value, input list_limit, output ready);
endinterface

// Result channel.
interface btt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        active_now;
    logic [15:0] listed_id;
    logic        last;

    modport source (output valid, output status, output slot, output active_now,
                    output listed_id, output last, input ready);
    modport sink   (input valid, input status, input slot, input active_now,
                    input listed_id, input last, output ready);
endinterface

`default_nettype wire

/* rtl/btt_ram.sv */
`default_nettype none

module btt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds when idle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/btt_front.sv */
`default_nettype none

module btt_front
    import btt_pkg::*;
#(
    parameter int MAX_TARGETS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    btt_req_if.sink    req,
    output      logic  cmd_valid,
    input  wire logic  cmd_ready,
    output      cmd_t  cmd
);

    localparam int LIMIT_CAP = (MAX_TARGETS < RESULT_CAP) ? MAX_TARGETS : RESULT_CAP;

    cmd_t               q_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic               known;
    logic               push;
    logic               pop;
    logic [LIMIT_W-1:0] limit_sat;
    cmd_t               cmd_in;

    // Classify: drop undefined request codes, saturate the list limit.
    assign known     = (req.req_type <= OP_CLEAR);
    assign limit_sat = (req.list_limit > LIMIT_W'(LIMIT_CAP)) ? LIMIT_W'(LIMIT_CAP)
                                                              : req.list_limit;

    always_comb
    begin
        cmd_in.op    = op_t'(req.req_type);
        cmd_in.id    = req.member_id;
        cmd_in.en    = req.enable_value;
        cmd_in.limit = limit_sat;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready && known;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Two-entry command queue between the front and the back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/btt_back.sv */
`default_nettype none

module btt_back
    import btt_pkg::*;
#(
    parameter int MAX_TARGETS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output      logic cmd_ready,
    input  wire cmd_t cmd,
    output      logic rsp_valid,
    input  wire logic rsp_ready,
    output      rsp_t rsp
);

    localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CW = $clog2(MAX_TARGETS + 1);
    localparam int DW = ID_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_CMP,
        S_LIST_END
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]      idx_reg;
    logic [LIMIT_W-1:0] n_reg;
    logic               pend_valid_reg;
    logic [ID_W-1:0]    pend_id_reg;
    logic [CW-1:0]      count_reg;
    logic               enabled_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic               free;
    logic [CW-1:0]      idx_inc;
    logic               at_end;
    logic               match;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_wdata;
    logic [DW-1:0]      ram_rdata;

    function automatic rsp_t make_rsp(status_t s, logic [SLOT_W-1:0] sl, logic act,
                                      logic [ID_W-1:0] id, logic lst);
        rsp_t r;
        r.status     = s;
        r.slot       = sl;
        r.active_now = act;
        r.listed_id  = id;
        r.last       = lst;
        return r;
    endfunction

    // Entry store: active mark over member id.
    btt_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TARGETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A result may be loaded when the output register is empty or being taken.
    assign free      = !out_valid_reg || rsp_ready;
    assign idx_inc   = idx_reg + CW'(1);
    assign at_end    = (idx_reg == count_reg);
    assign match     = (ram_rdata[ID_W-1:0] == id_reg);
    assign cmd_ready = (state_reg == S_IDLE) && free;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Memory port control, mirroring the sequencer below.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        unique case (state_reg)
            S_SRCH_RD:
            begin
                ram_re    = !at_end;
                ram_we    = at_end && (op_reg == OP_ADD) && free;
                ram_wdata = {1'b1, id_reg};
            end
            S_SRCH_CMP:
            begin
                ram_we    = match && (op_reg == OP_TOGGLE) && free;
                ram_wdata = {~ram_rdata[ID_W], ram_rdata[ID_W-1:0]};
            end
            S_SHIFT_RD:
            begin
                ram_re    = (idx_inc != count_reg);
                ram_raddr = idx_inc[AW-1:0];
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            S_LIST_RD:
            begin
                ram_re = !at_end;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer: table state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_ADD;
            id_reg         <= '0;
            limit_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            count_reg      <= '0;
            enabled_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && free)
                    begin
                        op_reg         <= cmd.op;
                        id_reg         <= cmd.id;
                        limit_reg      <= cmd.limit;
                        idx_reg        <= '0;
                        n_reg          <= '0;
                        pend_valid_reg <= 1'b0;
                        unique case (cmd.op)
                            OP_ADD:
                            begin
                                if (count_reg == CW'(MAX_TARGETS))
                                begin
                                    out_reg       <= make_rsp(ST_FULL, '0, 1'b0, '0, 1'b1);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_SRCH_RD;
                                end
                            end
                            OP_REMOVE, OP_TOGGLE:
                            begin
                                state_reg <= S_SRCH_RD;
                            end
                            OP_SET_EN:
                            begin
                                enabled_reg   <= cmd.en;
                                out_reg       <= make_rsp(ST_OK, '0, 1'b0, '0, 1'b1);
                                out_valid_reg <= 1'b1;
                            end
                            OP_LIST:
                            begin
                                if (!enabled_reg || (cmd.limit == '0) || (count_reg == '0))
                                begin
                                    out_reg       <= make_rsp(ST_EMPTY, '0, 1'b0, '0, 1'b1);
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_LIST_RD;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg     <= '0;
                                enabled_reg   <= 1'b0;
                                out_reg       <= make_rsp(ST_OK, '0, 1'b0, '0, 1'b1);
                                out_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // Search: read one entry, compare it in the next cycle.
                S_SRCH_RD:
                begin
                    if (!at_end)
                    begin
                        state_reg <= S_SRCH_CMP;
                    end
                    else if (free)
                    begin
                        if (op_reg == OP_ADD)
                        begin
                            count_reg <= count_reg + CW'(1);
                            out_reg   <= make_rsp(ST_OK, SLOT_W'(count_reg), 1'b0, '0, 1'b1);
                        end
                        else
                        begin
                            out_reg <= make_rsp(ST_NOT_FOUND, '0, 1'b0, '0, 1'b1);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_SRCH_CMP:
                begin
                    if (free)
                    begin
                        if (!match)
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_SRCH_RD;
                        end
                        else if (op_reg == OP_ADD)
                        begin
                            out_reg       <= make_rsp(ST_DUPLICATE, '0, 1'b0, '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else if (op_reg == OP_TOGGLE)
                        begin
                            out_reg       <= make_rsp(ST_OK, '0, ~ram_rdata[ID_W], '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_SHIFT_RD;
                        end
                    end
                end

                // Remove: move each later entry down by one.
                S_SHIFT_RD:
                begin
                    if (idx_inc != count_reg)
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                    else if (free)
                    begin
                        count_reg     <= count_reg - CW'(1);
                        out_reg       <= make_rsp(ST_OK, '0, 1'b0, '0, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SHIFT_RD;
                end

                // List: one found id is held back so that the final one can carry last.
                S_LIST_RD:
                begin
                    if (!at_end)
                    begin
                        state_reg <= S_LIST_CMP;
                    end
                    else if (free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg <= make_rsp(ST_OK, '0, 1'b0, pend_id_reg, 1'b1);
                        end
                        else
                        begin
                            out_reg <= make_rsp(ST_EMPTY, '0, 1'b0, '0, 1'b1);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_LIST_CMP:
                begin
                    if (free)
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_LIST_RD;
                        if (ram_rdata[ID_W])
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= make_rsp(ST_OK, '0, 1'b0, pend_id_reg, 1'b0);
                                out_valid_reg <= 1'b1;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_id_reg    <= ram_rdata[ID_W-1:0];
                            n_reg          <= n_reg + LIMIT_W'(1);
                            if ((n_reg + LIMIT_W'(1)) == limit_reg)
                            begin
                                state_reg <= S_LIST_END;
                            end
                        end
                    end
                end

                S_LIST_END:
                begin
                    if (free)
                    begin
                        out_reg       <= make_rsp(ST_OK, '0, 1'b0, pend_id_reg, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TARGETS))
        else $error("entry count above table size");

    // Writes land only on valid entries or on the append position.
    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} <= (AW+1)'(count_reg)))
        else $error("entry write beyond the table");

    // A list scan stops as soon as the limit is reached.
    a_list_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST_RD || state_reg == S_LIST_CMP) |-> (n_reg < limit_reg))
        else $error("list went past its limit");

    // Clear empties the table and disables the group.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.op == OP_CLEAR) |=> (count_reg == '0 && !enabled_reg))
        else $error("clear left the table populated");

endmodule

`default_nettype wire

/* rtl/broadcast_target_table_top.sv */
// Broadcast target table: a compacted list of member ids with active marks
// and a group enable bit.
//
// Channels: req carries one request per transaction (add, remove, toggle,
// set enable, list, clear); undefined request codes are taken and dropped.
// rsp returns the results; each request gives one transaction with last set,
// except a list that finds ids, which gives one transaction per id and sets
// last on the final one.
//
// Sequencing: requests pass a two-entry queue into a sequencer that reads
// the entry store with registered read data. A search reads each entry and
// compares it in the following state; a remove that matches then moves each
// later entry down by a read and a write; a list reads and checks each entry
// until the limit or the end. Set enable, clear and an add to a full table
// are answered from idle. The sequencer takes a new request only after it
// has finished the last one.
//
// Reset clears the count, the enable and all handshake state at once; no
// clearing pass is needed. When rsp stalls, the sequencer halts at its next
// compare or result step; the request queue takes up to two more requests.
`default_nettype none

module broadcast_target_table_top
    import btt_pkg::*;
#(
    parameter int MAX_TARGETS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    btt_req_if.sink   req,
    btt_rsp_if.source rsp
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    rsp_t rsp_data;

    // Front: classification and command queue.
    btt_front #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: table sequencer and result register.
    btt_back #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp       (rsp_data)
    );

    // Result channel drive.
    assign rsp.valid      = rsp_valid;
    assign rsp.status     = rsp_data.status;
    assign rsp.slot       = rsp_data.slot;
    assign rsp.active_now = rsp_data.active_now;
    assign rsp.listed_id  = rsp_data.listed_id;
    assign rsp.last       = rsp_data.last;

endmodule

`default_nettype wire
